/* rtl/core/dts_pkg.sv */
// Shared constants, codes and types for the depth-first topological sorter.
package dts_pkg;

    localparam int NODE_W        = 7;
    localparam int STAMP_W       = 8;
    localparam int OP_W          = 2;
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 1024;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ROOT,
        S_LOAD,
        S_WALK,
        S_EDGE,
        S_POP,
        S_EMIT_RD,
        S_EMIT_NODE,
        S_EMIT_OUT
    } t_state;

endpackage

/* rtl/core/dts_edge_store.sv */
// Adjacency store: per-node list ends, edge targets and next links.
module dts_edge_store import dts_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF,
    parameter int NW = $clog2(MAX_NODES + 1),
    parameter int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_nrd_en,
    input  logic [NW-1:0] i_nrd_addr,
    output logic [EW-1:0] o_head,
    output logic [EW-1:0] o_tail,
    output logic          o_head_valid,
    input  logic          i_nwr_en,
    input  logic [NW-1:0] i_nwr_addr,
    input  logic [EW-1:0] i_nwr_head,
    input  logic [EW-1:0] i_nwr_tail,
    input  logic          i_twr_en,
    input  logic [EW-1:0] i_twr_addr,
    input  logic [NW-1:0] i_twr_data,
    input  logic          i_lwr_en,
    input  logic [EW-1:0] i_lwr_addr,
    input  logic [EW-1:0] i_lwr_data,
    input  logic          i_erd_en,
    input  logic [EW-1:0] i_erd_addr,
    output logic [NW-1:0] o_target,
    output logic [EW-1:0] o_next
);

    logic [2*EW-1:0]     r_ends [MAX_NODES+1];
    logic [NW-1:0]       r_target [MAX_EDGES];
    logic [EW-1:0]       r_link [MAX_EDGES];
    logic [(1<<NW)-1:0]  r_hvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else if (i_clear) begin
            r_hvalid <= '0;
        end else if (i_nwr_en) begin
            r_hvalid[i_nwr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_nwr_en) begin
            r_ends[i_nwr_addr] <= {i_nwr_head, i_nwr_tail};
        end
        if (i_nrd_en) begin
            {o_head, o_tail} <= r_ends[i_nrd_addr];
            o_head_valid     <= r_hvalid[i_nrd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_twr_en) begin
            r_target[i_twr_addr] <= i_twr_data;
        end
        if (i_lwr_en) begin
            r_link[i_lwr_addr] <= i_lwr_data;
        end
        if (i_erd_en) begin
            o_target <= r_target[i_erd_addr];
            o_next   <= r_link[i_erd_addr];
        end
    end

endmodule

/* rtl/core/dts_stamp_store.sv */
// Per-node search results: visited marks, tree parent, discovery and finish stamps.
module dts_stamp_store import dts_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int NW = $clog2(MAX_NODES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic [NW-1:0]      i_vq_addr,
    output logic               o_visited,
    input  logic               i_enter_en,
    input  logic [NW-1:0]      i_enter_addr,
    input  logic [NW-1:0]      i_enter_parent,
    input  logic [STAMP_W-1:0] i_enter_stamp,
    input  logic               i_fin_en,
    input  logic [NW-1:0]      i_fin_addr,
    input  logic [STAMP_W-1:0] i_fin_stamp,
    input  logic               i_rd_en,
    input  logic [NW-1:0]      i_rd_addr,
    output logic [NW-1:0]      o_parent,
    output logic [STAMP_W-1:0] o_disc,
    output logic [STAMP_W-1:0] o_fin
);

    logic [(1<<NW)-1:0]  r_visited;
    logic [NW-1:0]       r_parent [MAX_NODES+1];
    logic [STAMP_W-1:0]  r_disc [MAX_NODES+1];
    logic [STAMP_W-1:0]  r_fin [MAX_NODES+1];

    assign o_visited = r_visited[i_vq_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
        end else if (i_clear) begin
            r_visited <= '0;
        end else if (i_enter_en) begin
            r_visited[i_enter_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enter_en) begin
            r_parent[i_enter_addr] <= i_enter_parent;
            r_disc[i_enter_addr]   <= i_enter_stamp;
        end
        if (i_fin_en) begin
            r_fin[i_fin_addr] <= i_fin_stamp;
        end
        if (i_rd_en) begin
            o_parent <= r_parent[i_rd_addr];
            o_disc   <= r_disc[i_rd_addr];
            o_fin    <= r_fin[i_rd_addr];
        end
    end

endmodule

/* rtl/core/dfs_topological_sort.sv */
// Depth-first topological sorter: edge loading, stack walk and result emission.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_operation, i_source_node, i_target_node
//  result   out        o_valid / i_stall  o_topo_node, o_parent_node, o_discover_stamp,
//                                         o_finish_stamp, o_last_result
//  config   in         i_cfg_we           i_cfg_data (node_count)
//
// Add edge writes the target and reads the list ends, then writes the list ends and, for a
// non-empty list, the link; a dropped edge or a clear leaves it idle. A run probes roots,
// walks edges, enters and finishes nodes, then emits them in reverse finish order.
// Reset is synchronous; edge memories are not cleared, the list valid bits are.
// A stalled result holds in the output register and emission waits; input stays stalled
// until the last result of the run is in the output register.
module dfs_topological_sort import dts_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [NODE_W-1:0]  i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [NODE_W-1:0]  i_source_node,
    input  logic [NODE_W-1:0]  i_target_node,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [NODE_W-1:0]  o_topo_node,
    output logic [NODE_W-1:0]  o_parent_node,
    output logic [STAMP_W-1:0] o_discover_stamp,
    output logic [STAMP_W-1:0] o_finish_stamp,
    output logic               o_last_result
);

    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = $clog2(MAX_NODES);
    localparam int FW = NW + 2 * EW + 1;

    t_state r_state, n_state;

    logic [NODE_W-1:0]  r_node_count;
    logic [CW-1:0]      r_edge_count;
    logic [NODE_W-1:0]  r_add_src;
    logic [NODE_W-1:0]  r_root;
    logic [NW-1:0]      r_enter;
    logic [NW-1:0]      r_depth;
    logic [NW-1:0]      r_posts;
    logic [NW-1:0]      r_emit;
    logic [NW-1:0]      r_emit_node;
    logic [STAMP_W-1:0] r_time;
    logic [NW-1:0]      r_top_node;
    logic [EW-1:0]      r_top_edge;
    logic [EW-1:0]      r_top_tail;
    logic               r_top_ev;
    logic [FW-1:0]      r_stack [MAX_NODES];
    logic [FW-1:0]      r_stack_q;
    logic [NW-1:0]      r_post [MAX_NODES];
    logic [NW-1:0]      r_post_q;

    logic [NODE_W-1:0]  w_n;
    logic               w_accept;
    logic               w_add_ok;
    logic               w_out_free;
    logic [NW-1:0]      w_dm1;
    logic [NW-1:0]      w_dm2;
    logic [NW-1:0]      w_em1;
    logic [STAMP_W-1:0] w_time_inc;
    logic               w_push;
    logic               w_nev;

    // edge store wires
    logic               w_nrd_en, w_nwr_en, w_twr_en, w_lwr_en, w_erd_en, w_eclear;
    logic [NW-1:0]      w_nrd_addr;
    logic [EW-1:0]      w_nwr_head, w_nwr_tail;
    logic [EW-1:0]      w_head, w_tail, w_next;
    logic               w_hv;
    logic [NW-1:0]      w_target;

    // stamp store wires
    logic               w_sclear, w_enter_en, w_fin_en, w_srd_en, w_visited;
    logic [NW-1:0]      w_vq_addr, w_enter_addr, w_enter_parent;
    logic [NW-1:0]      w_parent;
    logic [STAMP_W-1:0] w_disc, w_fin;

    assign w_n        = (r_node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_node_count;
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_add_ok   = (i_source_node != '0) && (i_source_node <= w_n)
                     && (i_target_node != '0) && (i_target_node <= w_n)
                     && (r_edge_count < CW'(MAX_EDGES));
    assign w_out_free = !o_valid || !i_stall;
    assign w_dm1      = r_depth - 1'b1;
    assign w_dm2      = r_depth - NW'(2);
    assign w_em1      = r_emit - 1'b1;
    assign w_time_inc = r_time + 1'b1;
    // the edge just read is the last of its list when it is the list tail
    assign w_nev      = (r_top_edge != r_top_tail);
    assign w_push     = (w_target != '0) && (NODE_W'(w_target) <= w_n) && !w_visited
                     && (r_depth < NW'(MAX_NODES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_nrd_en       = 1'b0;
        w_nrd_addr     = '0;
        w_nwr_en       = 1'b0;
        w_nwr_head     = w_head;
        w_nwr_tail     = r_edge_count[EW-1:0];
        w_twr_en       = 1'b0;
        w_lwr_en       = 1'b0;
        w_erd_en       = 1'b0;
        w_eclear       = 1'b0;
        w_sclear       = 1'b0;
        w_enter_en     = 1'b0;
        w_enter_addr   = r_root[NW-1:0];
        w_enter_parent = '0;
        w_fin_en       = 1'b0;
        w_srd_en       = 1'b0;
        w_vq_addr      = r_root[NW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_ADD) begin
                        if (w_add_ok) begin
                            w_twr_en   = 1'b1;
                            w_nrd_en   = 1'b1;
                            w_nrd_addr = i_source_node[NW-1:0];
                            n_state    = S_ADD;
                        end
                    end else if (i_operation == OP_CLEAR) begin
                        w_eclear = 1'b1;
                    end else if (i_operation == OP_RUN) begin
                        w_sclear = 1'b1;
                        n_state  = S_ROOT;
                    end
                end
            end
            S_ADD: begin
                w_nwr_en = 1'b1;
                if (w_hv) begin
                    w_lwr_en = 1'b1;
                end else begin
                    w_nwr_head = r_edge_count[EW-1:0];
                end
                n_state = S_IDLE;
            end
            S_ROOT: begin
                if (r_root > w_n) begin
                    n_state = S_EMIT_RD;
                end else if (!w_visited) begin
                    w_enter_en = 1'b1;
                    w_nrd_en   = 1'b1;
                    w_nrd_addr = r_root[NW-1:0];
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_top_ev) begin
                    w_erd_en = 1'b1;
                    n_state  = S_EDGE;
                end else begin
                    w_fin_en = 1'b1;
                    n_state  = (r_depth == NW'(1)) ? S_ROOT : S_POP;
                end
            end
            S_EDGE: begin
                w_vq_addr = w_target;
                if (w_push) begin
                    w_enter_en     = 1'b1;
                    w_enter_addr   = w_target;
                    w_enter_parent = r_top_node;
                    w_nrd_en       = 1'b1;
                    w_nrd_addr     = w_target;
                    n_state        = S_LOAD;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_POP: begin
                n_state = S_WALK;
            end
            S_EMIT_RD: begin
                n_state = (r_emit == '0) ? S_IDLE : S_EMIT_NODE;
            end
            S_EMIT_NODE: begin
                w_srd_en = 1'b1;
                n_state  = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (w_out_free) begin
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
        end else if (w_eclear) begin
            r_edge_count <= '0;
        end else if (r_state == S_ADD) begin
            r_edge_count <= r_edge_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_depth <= '0;
            r_posts <= '0;
            r_emit  <= '0;
            r_time  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_operation == OP_RUN) begin
                        r_root  <= NODE_W'(1);
                        r_depth <= '0;
                        r_posts <= '0;
                        r_time  <= '0;
                    end
                end
                S_ROOT: begin
                    if (r_root > w_n) begin
                        r_emit <= r_posts;
                    end else if (w_visited) begin
                        r_root <= r_root + 1'b1;
                    end else begin
                        r_time <= w_time_inc;
                    end
                end
                S_LOAD: begin
                    r_depth <= r_depth + 1'b1;
                end
                S_WALK: begin
                    if (!r_top_ev) begin
                        r_time  <= w_time_inc;
                        r_depth <= w_dm1;
                        if (r_posts < NW'(MAX_NODES)) begin
                            r_posts <= r_posts + 1'b1;
                        end
                        if (r_depth == NW'(1)) begin
                            r_root <= r_root + 1'b1;
                        end
                    end
                end
                S_EDGE: begin
                    if (w_push) begin
                        r_time <= w_time_inc;
                    end
                end
                S_EMIT_OUT: begin
                    if (w_out_free) begin
                        r_emit <= w_em1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // top of stack lives in registers, deeper entries in the stack memory
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_add_src <= i_source_node;
            end
            S_ROOT: begin
                r_enter <= r_root[NW-1:0];
            end
            S_LOAD: begin
                r_top_node <= r_enter;
                r_top_edge <= w_head;
                r_top_tail <= w_tail;
                r_top_ev   <= w_hv;
            end
            S_EDGE: begin
                r_enter    <= w_target;
                r_top_edge <= w_next;
                r_top_ev   <= w_nev;
                if (w_push) begin
                    r_stack[w_dm1[SW-1:0]] <= {r_top_node, w_next, r_top_tail, w_nev};
                end
            end
            S_WALK: begin
                if (!r_top_ev) begin
                    if (r_posts < NW'(MAX_NODES)) begin
                        r_post[r_posts[SW-1:0]] <= r_top_node;
                    end
                    r_stack_q <= r_stack[w_dm2[SW-1:0]];
                end
            end
            S_POP: begin
                {r_top_node, r_top_edge, r_top_tail, r_top_ev} <= r_stack_q;
            end
            S_EMIT_RD: begin
                r_post_q <= r_post[w_em1[SW-1:0]];
            end
            S_EMIT_NODE: begin
                r_emit_node <= r_post_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_EMIT_OUT && w_out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT_OUT && w_out_free) begin
            o_topo_node      <= NODE_W'(r_emit_node);
            o_parent_node    <= NODE_W'(w_parent);
            o_discover_stamp <= w_disc;
            o_finish_stamp   <= w_fin;
            o_last_result    <= (r_emit == NW'(1));
        end
    end

    dts_edge_store #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .NW        (NW),
        .EW        (EW)
    ) u_edges (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_eclear),
        .i_nrd_en     (w_nrd_en),
        .i_nrd_addr   (w_nrd_addr),
        .o_head       (w_head),
        .o_tail       (w_tail),
        .o_head_valid (w_hv),
        .i_nwr_en     (w_nwr_en),
        .i_nwr_addr   (r_add_src[NW-1:0]),
        .i_nwr_head   (w_nwr_head),
        .i_nwr_tail   (w_nwr_tail),
        .i_twr_en     (w_twr_en),
        .i_twr_addr   (r_edge_count[EW-1:0]),
        .i_twr_data   (i_target_node[NW-1:0]),
        .i_lwr_en     (w_lwr_en),
        .i_lwr_addr   (w_tail),
        .i_lwr_data   (r_edge_count[EW-1:0]),
        .i_erd_en     (w_erd_en),
        .i_erd_addr   (r_top_edge),
        .o_target     (w_target),
        .o_next       (w_next)
    );

    dts_stamp_store #(
        .MAX_NODES (MAX_NODES),
        .NW        (NW)
    ) u_stamps (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (w_sclear),
        .i_vq_addr      (w_vq_addr),
        .o_visited      (w_visited),
        .i_enter_en     (w_enter_en),
        .i_enter_addr   (w_enter_addr),
        .i_enter_parent (w_enter_parent),
        .i_enter_stamp  (w_time_inc),
        .i_fin_en       (w_fin_en),
        .i_fin_addr     (r_top_node),
        .i_fin_stamp    (w_time_inc),
        .i_rd_en        (w_srd_en),
        .i_rd_addr      (r_post_q),
        .o_parent       (w_parent),
        .o_disc         (w_disc),
        .o_fin          (w_fin)
    );

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NW'(MAX_NODES))
        else $error("walk depth beyond node limit");

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= CW'(MAX_EDGES))
        else $error("edge count beyond store size");

    a_time_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_root > w_n) |-> (r_time == STAMP_W'({r_posts, 1'b0})))
        else $error("time counter does not match two stamps per finished node");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_NODE) |-> (r_emit != '0 && r_emit <= r_posts))
        else $error("emission index out of range");
`endif

endmodule
